[rtl/core/wopi_pkg.sv]
// Package: constants, types and helper functions of the wheel odometry pose integrator.
package wopi_pkg;

    localparam int          CORDIC_STEPS_DEF = 16;
    localparam logic [31:0] DPT_RESET        = 32'd41177;
    localparam logic [31:0] RATE_TO_BAM      = 32'd44798134;
    localparam logic [33:0] CORDIC_X0        = 34'sd652032874;
    localparam int          CW               = 34;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] cs;
        logic signed [CW-1:0] sn;
    } t_cordic_res;

    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
        logic signed [47:0] r;
        if (v > 51'sh0_7FFF_FFFF_FFFF) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < -51'sh0_8000_0000_0000) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/wopi_in_if.sv]
// Interface: odometry sample channel.
interface wopi_in_if;
    logic               valid;
    logic               ready;
    logic        [31:0] timestamp_us;
    logic signed [15:0] steer_angle;
    logic signed [31:0] encoder_count;
    logic signed [31:0] angular_rate;

    modport source (output valid, timestamp_us, steer_angle, encoder_count, angular_rate,
                    input ready);
    modport sink   (input valid, timestamp_us, steer_angle, encoder_count, angular_rate,
                    output ready);
endinterface

[rtl/core/wopi_out_if.sv]
// Interface: pose result channel.
interface wopi_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic        [31:0] heading;
    logic signed [47:0] odometer_total;

    modport source (output valid, pos_x, pos_y, heading, odometer_total, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, odometer_total, output ready);
endinterface

[rtl/core/wopi_mul.sv]
// Shared registered 32x32 unsigned multiplier.
module wopi_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;
endmodule

[rtl/core/wopi_cordic.sv]
// Iterative rotation-mode CORDIC producing cosine and sine of a binary angle.
module wopi_cordic #(
    parameter int CORDIC_STEPS = wopi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_ang,
    output wopi_pkg::t_cordic_res o_res
);
    localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int IW    = $clog2(STEPS + 1);

    logic                          r_busy;
    logic                          r_done;
    logic                          r_flip;
    logic [IW-1:0]                 r_i;
    logic signed [wopi_pkg::CW-1:0] r_x;
    logic signed [wopi_pkg::CW-1:0] r_y;
    logic signed [wopi_pkg::CW-1:0] r_z;
    logic signed [wopi_pkg::CW-1:0] w_xs;
    logic signed [wopi_pkg::CW-1:0] w_ys;
    logic signed [wopi_pkg::CW-1:0] w_at;
    logic [31:0]                   w_ang;
    logic                          w_flip;

    assign w_flip = (i_ang[31:30] == 2'b01) || (i_ang[31:30] == 2'b10);
    assign w_ang  = w_flip ? (i_ang + 32'h8000_0000) : i_ang;
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_at   = $signed({2'b00, wopi_pkg::atan_bam(5'(r_i))});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == IW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_i <= r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_flip <= w_flip;
            r_x    <= $signed(wopi_pkg::CORDIC_X0);
            r_y    <= '0;
            r_z    <= $signed({{2{w_ang[31]}}, w_ang});
        end else if (r_busy) begin
            if (!r_z[wopi_pkg::CW-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.cs   = r_flip ? -r_x : r_x;
    assign o_res.sn   = r_flip ? -r_y : r_y;
endmodule

[rtl/core/wheel_odometry_pose_integrator_unit.sv]
// Top level: dead-reckoning pose integrator with sequencer and shared arithmetic.
//
// Usage: odometry samples enter on the sample channel (valid/ready); each accepted
// beat yields exactly one pose beat on the result channel. The distance per tick
// register is written through i_cfg_we / i_cfg_wdata; the user must do so only while
// the block is idle, as the block itself does not enforce this. The first sample
// after reset only latches time and count; its unchanged pose goes through the
// S_OUT state into the output register. Every later sample runs the distance and
// heading products, a CORDIC pass on the steering angle, the forward scaling, a
// CORDIC pass on the heading and the x and y products: two passes of the iterative
// CORDIC and ten issues to the single shared registered multiplier. Input ready is
// high only while the sequencer is idle, so one sample is worked on at a time.
// The finished pose sits in an output register; if the receiver stalls, the
// result stays there and the next finished pose waits until it is taken.
// Reset (synchronous, active low) clears the pose, heading, odometer and the
// first-sample flag, and restores distance per tick to its default.
module wheel_odometry_pose_integrator_unit #(
    parameter int CORDIC_STEPS = wopi_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wopi_in_if.sink     i_in,
    wopi_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_D    = 15'b000000000000010,
        S_H1   = 15'b000000000000100,
        S_H2   = 15'b000000000001000,
        S_H3   = 15'b000000000010000,
        S_H4   = 15'b000000000100000,
        S_C1   = 15'b000000001000000,
        S_F1   = 15'b000000010000000,
        S_F2   = 15'b000000100000000,
        S_C2   = 15'b000001000000000,
        S_X1   = 15'b000010000000000,
        S_X2   = 15'b000100000000000,
        S_Y1   = 15'b001000000000000,
        S_Y2   = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } t_state;

    t_state             r_state;
    logic [31:0]        r_dpt;
    logic               r_started;
    logic [31:0]        r_last_time;
    logic [31:0]        r_last_count;
    logic [31:0]        r_heading;
    logic signed [47:0] r_x;
    logic signed [47:0] r_y;
    logic signed [47:0] r_travel;
    logic [31:0]        r_dt;
    logic [31:0]        r_tick_mag;
    logic               r_tick_neg;
    logic [31:0]        r_rate_mag;
    logic               r_rate_neg;
    logic [15:0]        r_steer;
    logic [48:0]        r_dist_mag;
    logic               r_dist_neg;
    logic [48:0]        r_fwd_mag;
    logic               r_fwd_neg;
    logic [63:0]        r_m;
    logic [63:0]        r_t;
    logic signed [33:0] r_cs;
    logic signed [33:0] r_sn;
    logic               r_ov;
    logic signed [47:0] r_ox;
    logic signed [47:0] r_oy;
    logic [31:0]        r_oh;
    logic signed [47:0] r_ot;

    logic [31:0]           w_ma;
    logic [31:0]           w_mb;
    logic [63:0]           w_prod;
    logic                  w_cstart;
    logic [31:0]           w_cang;
    wopi_pkg::t_cordic_res w_cres;
    logic [31:0]           w_dtick;
    logic [31:0]           w_abs_cs;
    logic [31:0]           w_abs_sn;
    logic [87:0]           w_wide;
    logic [57:0]           w_q30;
    logic signed [50:0]    w_term;
    logic [31:0]           w_dh;
    logic signed [49:0]    w_dist;
    logic                  w_load;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_dtick    = i_in.encoder_count - r_last_count;
    assign w_abs_cs   = r_cs[33] ? 32'(-r_cs) : 32'(r_cs);
    assign w_abs_sn   = r_sn[33] ? 32'(-r_sn) : 32'(r_sn);
    assign w_wide     = {r_t[63:0], 24'd0} + 88'(w_prod);
    assign w_q30      = w_wide[87:30];
    assign w_dh       = r_t[31:0] + w_prod[63:32];
    assign w_dist     = r_dist_neg ? -$signed({1'b0, r_dist_mag}) : $signed({1'b0, r_dist_mag});
    assign w_load     = (r_state == S_OUT) && (!r_ov || o_out.ready);

    always_comb begin
        w_term = $signed({1'b0, w_q30[49:0]});
        if (r_state == S_X2) begin
            if (r_fwd_neg ^ r_cs[33]) begin
                w_term = -$signed({1'b0, w_q30[49:0]});
            end
        end else if (r_fwd_neg ^ r_sn[33]) begin
            w_term = -$signed({1'b0, w_q30[49:0]});
        end
    end

    always_comb begin
        w_ma     = '0;
        w_mb     = '0;
        w_cstart = 1'b0;
        w_cang   = {r_steer, 16'd0};
        unique case (r_state)
            S_D: begin
                w_ma = r_tick_mag;
                w_mb = r_dpt;
            end
            S_H1: begin
                w_ma = r_rate_mag;
                w_mb = r_dt;
            end
            S_H2: begin
                w_ma = w_prod[63:32];
                w_mb = wopi_pkg::RATE_TO_BAM;
            end
            S_H3: begin
                w_ma = r_m[31:0];
                w_mb = wopi_pkg::RATE_TO_BAM;
            end
            S_H4: begin
                w_cstart = 1'b1;
            end
            S_C1: begin
                w_ma = 32'(r_dist_mag[48:24]);
                w_mb = (w_cres.cs[33]) ? 32'(-w_cres.cs) : 32'(w_cres.cs);
            end
            S_F1: begin
                w_ma = 32'(r_dist_mag[23:0]);
                w_mb = w_abs_cs;
            end
            S_F2: begin
                w_cstart = 1'b1;
                w_cang   = r_heading;
            end
            S_C2: begin
                w_ma = 32'(r_fwd_mag[48:24]);
                w_mb = (w_cres.cs[33]) ? 32'(-w_cres.cs) : 32'(w_cres.cs);
            end
            S_X1: begin
                w_ma = 32'(r_fwd_mag[23:0]);
                w_mb = w_abs_cs;
            end
            S_X2: begin
                w_ma = 32'(r_fwd_mag[48:24]);
                w_mb = w_abs_sn;
            end
            S_Y1: begin
                w_ma = 32'(r_fwd_mag[23:0]);
                w_mb = w_abs_sn;
            end
            default: begin
            end
        endcase
    end

    wopi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    wopi_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_ang   (w_cang),
        .o_res   (w_cres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dpt        <= wopi_pkg::DPT_RESET;
            r_started    <= 1'b0;
            r_last_time  <= '0;
            r_last_count <= '0;
            r_heading    <= '0;
            r_x          <= '0;
            r_y          <= '0;
            r_travel     <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dpt <= i_cfg_wdata;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_started    <= 1'b1;
                        r_last_time  <= i_in.timestamp_us;
                        r_last_count <= i_in.encoder_count;
                        r_state      <= r_started ? S_D : S_OUT;
                    end
                end
                S_D: r_state <= S_H1;
                S_H1: r_state <= S_H2;
                S_H2: begin
                    r_travel <= wopi_pkg::sat48(51'(r_travel) + 51'(w_dist));
                    r_state  <= S_H3;
                end
                S_H3: r_state <= S_H4;
                S_H4: begin
                    r_heading <= r_heading + (r_rate_neg ? -w_dh : w_dh);
                    r_state   <= S_C1;
                end
                S_C1: begin
                    if (w_cres.done) begin
                        r_state <= S_F1;
                    end
                end
                S_F1: r_state <= S_F2;
                S_F2: r_state <= S_C2;
                S_C2: begin
                    if (w_cres.done) begin
                        r_state <= S_X1;
                    end
                end
                S_X1: r_state <= S_X2;
                S_X2: begin
                    r_x     <= wopi_pkg::sat48(51'(r_x) + w_term);
                    r_state <= S_Y1;
                end
                S_Y1: r_state <= S_Y2;
                S_Y2: begin
                    r_y     <= wopi_pkg::sat48(51'(r_y) + w_term);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in.valid) begin
            r_dt       <= i_in.timestamp_us - r_last_time;
            r_tick_neg <= w_dtick[31];
            r_tick_mag <= w_dtick[31] ? -w_dtick : w_dtick;
            r_rate_neg <= i_in.angular_rate[31];
            r_rate_mag <= i_in.angular_rate[31] ? 32'(-i_in.angular_rate)
                                                : 32'(i_in.angular_rate);
            r_steer    <= i_in.steer_angle;
        end
        if (r_state == S_H1) begin
            r_dist_neg <= r_tick_neg;
            r_dist_mag <= (w_prod[63:48] != '0) ? 49'h1_0000_0000_0000 : w_prod[48:0];
        end
        if (r_state == S_H2) begin
            r_m <= w_prod;
        end
        if ((r_state == S_H3) || (r_state == S_F1) || (r_state == S_X1)
            || (r_state == S_Y1)) begin
            r_t <= w_prod;
        end
        if ((r_state == S_C1) && w_cres.done) begin
            r_cs <= w_cres.cs;
        end
        if (r_state == S_F2) begin
            r_fwd_neg <= r_dist_neg ^ r_cs[33];
            r_fwd_mag <= (w_q30 > 58'h1_0000_0000_0000) ? 49'h1_0000_0000_0000
                                                        : w_q30[48:0];
        end
        if ((r_state == S_C2) && w_cres.done) begin
            r_cs <= w_cres.cs;
            r_sn <= w_cres.sn;
        end
        if (w_load) begin
            r_ox <= r_x;
            r_oy <= r_y;
            r_oh <= r_heading;
            r_ot <= r_travel;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.pos_x          = r_ox;
    assign o_out.pos_y          = r_oy;
    assign o_out.heading        = r_oh;
    assign o_out.odometer_total = r_ot;

    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && r_started) |=> (r_state == S_D))
        else $error("started sample did not enter the multiply sequence");

    a_cordic_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cres.done |-> ((r_state == S_C1) || (r_state == S_C2)))
        else $error("cordic finished outside a wait state");

    a_heading_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && ($past(r_state) != S_H4)) |-> $stable(r_heading))
        else $error("heading changed outside its update step");
endmodule

[tb/wheel_odometry_pose_integrator_unit_tb.sv]
// Testbench: self-checking pose prediction against the odometry pose integrator top level.
module wheel_odometry_pose_integrator_unit_tb;

    localparam int          STEP_COUNT = wopi_pkg::CORDIC_STEPS_DEF;
    localparam int          SETTLE_CYC = 2 * STEP_COUNT + 40;
    localparam int          CYCLE_CAP  = 1000000;
    localparam longint      POS_HI     = 64'sd140737488355327;
    localparam longint      POS_LO     = -64'sd140737488355328;
    localparam longint      TRAVEL_LIM = 64'sd281474976710656;
    localparam longint      GAIN_INV   = 64'sd652032874;
    localparam longint      ATAN_TAB [32] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        667544, 333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608,
        1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef struct {
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic        [31:0] hdg;
        logic signed [47:0] odo;
    } t_pose;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [31:0] i_cfg_wdata;

    wopi_in_if  in_ch ();
    wopi_out_if out_ch ();

    wheel_odometry_pose_integrator_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predictor state
    logic [31:0] dist_per_tick;
    bit          have_first;
    logic [31:0] prev_time;
    logic [31:0] prev_count;
    logic [31:0] heading_m;
    longint      x_m;
    longint      y_m;
    longint      travel_m;

    t_pose   pose_q [$];
    int      err_cnt;
    int      beats_in;
    int      beats_out;
    int      cyc;
    bit      quiet;
    int      stall_left;
    logic [31:0] gen_time;
    logic [31:0] gen_count;

    always #4 i_clk = ~i_clk;

    function automatic longint clamp64(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint scale_q30(input longint a, input longint c);
        bit                  neg;
        longint unsigned     ma;
        longint unsigned     mc;
        longint unsigned     t;
        longint unsigned     u;
        longint unsigned     r;
        neg = (a < 0) != (c < 0);
        ma  = a < 0 ? longint'(-a) : a;
        mc  = c < 0 ? longint'(-c) : c;
        t   = (ma >> 24) * mc;
        u   = (ma & 64'hFFFFFF) * mc;
        r   = (t >> 6) + ((((t & 64'd63) << 24) + u) >> 30);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    task automatic rotate_sincos(input logic [31:0] ang, output longint c, output longint s);
        bit     flip;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        if (flip) begin
            ang = ang + 32'h80000000;
        end
        z = longint'($signed(ang));
        x = GAIN_INV;
        y = 0;
        for (int i = 0; i < STEP_COUNT; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_pose(input logic [31:0] ts, input logic [15:0] steer,
                                input logic [31:0] cnt, input logic [31:0] rate,
                                output t_pose p);
        logic [31:0]     dt;
        logic [31:0]     dtu;
        longint          trav;
        longint          fwd;
        longint unsigned mr;
        longint unsigned m;
        longint unsigned dh;
        longint          cs;
        longint          sn;
        if (!have_first) begin
            have_first = 1'b1;
            prev_time  = ts;
            prev_count = cnt;
        end else begin
            dt         = ts - prev_time;
            dtu        = cnt - prev_count;
            prev_time  = ts;
            prev_count = cnt;
            trav = clamp64(longint'($signed(dtu)) * longint'({32'd0, dist_per_tick}),
                           -TRAVEL_LIM, TRAVEL_LIM);
            travel_m = clamp64(travel_m + trav, POS_LO, POS_HI);
            mr = rate[31] ? 64'h1_0000_0000 - {32'd0, rate} : {32'd0, rate};
            m  = mr * {32'd0, dt};
            dh = (m >> 32) * wopi_pkg::RATE_TO_BAM
                 + (((m & 64'hFFFFFFFF) * wopi_pkg::RATE_TO_BAM) >> 32);
            if (rate[31]) begin
                dh = 64'd0 - dh;
            end
            heading_m = heading_m + dh[31:0];
            rotate_sincos({steer, 16'h0}, cs, sn);
            fwd = clamp64(scale_q30(trav, cs), -TRAVEL_LIM, TRAVEL_LIM);
            rotate_sincos(heading_m, cs, sn);
            x_m = clamp64(x_m + scale_q30(fwd, cs), POS_LO, POS_HI);
            y_m = clamp64(y_m + scale_q30(fwd, sn), POS_LO, POS_HI);
        end
        p.x   = x_m[47:0];
        p.y   = y_m[47:0];
        p.hdg = heading_m;
        p.odo = travel_m[47:0];
    endtask

    task automatic send_sample(input logic [31:0] ts, input logic [15:0] steer,
                               input logic [31:0] cnt, input logic [31:0] rate);
        t_pose p;
        int    gap;
        @(negedge i_clk);
        in_ch.valid         = 1'b1;
        in_ch.timestamp_us  = ts;
        in_ch.steer_angle   = steer;
        in_ch.encoder_count = cnt;
        in_ch.angular_rate  = rate;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        predict_pose(ts, steer, cnt, rate, p);
        pose_q.push_back(p);
        beats_in++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid = 1'b0;
            end
        end
    endtask

    task automatic drain_idle();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pose_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_dpt(input logic [31:0] v);
        drain_idle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        dist_per_tick = v;
    endtask

    task automatic send_random(input int wellformed_pct);
        logic [31:0] ts;
        logic [15:0] steer;
        logic [31:0] cnt;
        logic [31:0] rate;
        if ($urandom_range(0, 99) < wellformed_pct) begin
            ts    = gen_time + $urandom_range(200, 20000);
            cnt   = gen_count + $urandom_range(0, 600) - 150;
            steer = $urandom_range(0, 1) ? 16'($urandom)
                                         : 16'($urandom_range(0, 12000) - 6000);
            rate  = $urandom_range(0, 3) == 0 ? $urandom
                                              : $urandom_range(0, 32'h80000) - 32'h40000;
        end else begin
            ts = $urandom; steer = 16'($urandom); cnt = $urandom; rate = $urandom;
        end
        gen_time  = ts;
        gen_count = cnt;
        send_sample(ts, steer, cnt, rate);
    endtask

    task automatic test_directed();
        send_sample(32'd1000, 16'd0, 32'd0, 32'd0);
        send_sample(32'd1000, 16'd0, 32'd0, 32'd0);
        send_sample(32'd2000, 16'd0, 32'd100, 32'h0001_0000);
        send_sample(32'd3000, 16'h7FFF, 32'd200, 32'hFFFF_0000);
        send_sample(32'd4000, 16'h8000, 32'd300, 32'h7FFF_FFFF);
        send_sample(32'd5000, 16'h4000, 32'd400, 32'h8000_0000);
        send_sample(32'd6000, 16'hC000, 32'd500, 32'h0000_0001);
        send_sample(32'hFFFF_FFF0, 16'h2000, 32'd600, 32'hFFFF_FFFF);
        send_sample(32'h0000_0100, 16'hE000, 32'd700, 32'h0003_0000);
        send_sample(32'h0000_0200, 16'h0001, 32'h7FFF_FFFF, 32'd0);
        send_sample(32'h0000_0300, 16'hFFFF, 32'h8000_0000, 32'd0);
        send_sample(32'h0000_0400, 16'd0, 32'hFFFF_FF00, 32'h0000_8000);
        send_sample(32'h0000_0500, 16'd0, 32'h0000_0040, 32'hFFFF_8000);
        send_sample(32'hFFFF_FFFF, 16'h1234, 32'h0000_0080, 32'h0010_0000);
        send_sample(32'h0000_0000, 16'hEDCB, 32'h0000_00C0, 32'hFFF0_0000);
        gen_time  = 32'd0;
        gen_count = 32'hC0;
    endtask

    task automatic test_config_extremes();
        logic [31:0] settings [5];
        settings = '{32'd0, 32'hFFFF_FFFF, 32'h0100_0000, $urandom, wopi_pkg::DPT_RESET};
        foreach (settings[k]) begin
            write_dpt(settings[k]);
            repeat (30) send_random(50);
        end
    endtask

    task automatic test_random_stream();
        for (int n = 0; n < 1500; n++) begin
            if (n % 300 == 299) begin
                write_dpt($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1000, 200000));
            end
            if (n == 700) begin
                drain_idle();
            end
            send_random(85);
        end
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        repeat (180) send_random(85);
    endtask

    always @(negedge i_clk) begin
        if (quiet) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left   <= $urandom_range(0, 12);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_pose e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            beats_out++;
            if (pose_q.size() == 0) begin
                err_cnt++;
                $display("%0t: pose beat with none pending x=%h", $time, out_ch.pos_x);
            end else begin
                e = pose_q.pop_front();
                if (out_ch.pos_x !== e.x) begin
                    err_cnt++;
                    $display("%0t: pos_x exp %h act %h", $time, e.x, out_ch.pos_x);
                end
                if (out_ch.pos_y !== e.y) begin
                    err_cnt++;
                    $display("%0t: pos_y exp %h act %h", $time, e.y, out_ch.pos_y);
                end
                if (out_ch.heading !== e.hdg) begin
                    err_cnt++;
                    $display("%0t: heading exp %h act %h", $time, e.hdg, out_ch.heading);
                end
                if (out_ch.odometer_total !== e.odo) begin
                    err_cnt++;
                    $display("%0t: odometer exp %h act %h", $time, e.odo,
                             out_ch.odometer_total);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cyc++;
        if (cyc > CYCLE_CAP) begin
            $display("timeout at %0t with %0d poses pending", $time, pose_q.size());
            $display("wheel_odometry_pose_integrator_unit_tb: errors");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0; i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0;
        in_ch.valid = 1'b0; in_ch.timestamp_us = '0; in_ch.steer_angle = '0;
        in_ch.encoder_count = '0; in_ch.angular_rate = '0; out_ch.ready = 1'b0;
        err_cnt = 0; beats_in = 0; beats_out = 0; cyc = 0; quiet = 1'b0; stall_left = 0;
        dist_per_tick = wopi_pkg::DPT_RESET; have_first = 1'b0; prev_time = '0;
        prev_count = '0;
        heading_m = '0; x_m = 0; y_m = 0; travel_m = 0;
        gen_time = '0; gen_count = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_random_stream();
        test_back_to_back();
        drain_idle();
        $display("covered %0d samples in, %0d poses out, directed extremes, several distance",
                 beats_in, beats_out);
        $display("settings incl. zero and full scale, random stalls and a back-to-back tail");
        if (err_cnt == 0) begin
            $display("wheel_odometry_pose_integrator_unit_tb: clean");
        end else begin
            $display("wheel_odometry_pose_integrator_unit_tb: errors");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/wopi_pkg.sv
rtl/core/wopi_in_if.sv
rtl/core/wopi_out_if.sv
rtl/core/wopi_mul.sv
rtl/core/wopi_cordic.sv
rtl/core/wheel_odometry_pose_integrator_unit.sv
tb/wheel_odometry_pose_integrator_unit_tb.sv
